// ----- rtl/core/sbw_pkg.sv -----
// Package: shared constants, opcodes and control types for the SBW master.
`timescale 1ns / 1ps
package sbw_pkg;

   localparam int unsigned DATA_W         = 16;
   localparam int unsigned SHORT_BITS     = 8;
   localparam int unsigned MAX_SHIFT_DEF  = 16;
   localparam int unsigned OP_W           = 3;

   typedef enum logic [OP_W-1:0] {
      OP_IR_SHIFT8  = 3'd0,
      OP_DR_SHIFT8  = 3'd1,
      OP_DR_SHIFT16 = 3'd2,
      OP_TCLK_CLR   = 3'd3,
      OP_TCLK_SET   = 3'd4
   } sbw_op_type;

   typedef struct packed {
      logic load;
      logic short_len;
      logic step;
   } sbw_shift_ctrl_type;

   typedef struct packed {
      logic              tms_level;
      logic              restore_level;
      logic              tdi_level;
      logic              tdo_sampled;
      logic [DATA_W-1:0] data_out;
      logic              last;
   } sbw_beat_type;

endpackage

// ----- rtl/core/sbw_if.sv -----
// Interfaces: command and SBW-cycle channels with valid/ready handshake.
`timescale 1ns / 1ps
interface sbw_req_if import sbw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [DATA_W-1:0] data_in;
   logic [DATA_W-1:0] tdo_bits;

   modport source (output valid, opcode, data_in, tdo_bits, input ready);
   modport sink   (input valid, opcode, data_in, tdo_bits, output ready);
endinterface

interface sbw_rsp_if import sbw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              tms_level;
   logic              restore_level;
   logic              tdi_level;
   logic              tdo_sampled;
   logic [DATA_W-1:0] data_out;
   logic              last;

   modport source (output valid, tms_level, restore_level, tdi_level, tdo_sampled,
                   data_out, last, input ready);
   modport sink   (input valid, tms_level, restore_level, tdi_level, tdo_sampled,
                   data_out, last, output ready);
endinterface

// ----- rtl/core/sbw_shifter.sv -----
// TDI/TDO shift registers: one data bit out and one captured bit in per step.
`timescale 1ns / 1ps
module sbw_shifter import sbw_pkg::*; #(
   parameter int unsigned MAX_SHIFT_BITS = MAX_SHIFT_DEF
) (
   input  logic               clock,
   input  logic [DATA_W-1:0]  data_in,
   input  logic [DATA_W-1:0]  tdo_bits,
   input  sbw_shift_ctrl_type ctrl,
   output logic               tdi_bit,
   output logic [DATA_W-1:0]  captured
);

   localparam int unsigned SHIFT_W     = (MAX_SHIFT_BITS < DATA_W) ? MAX_SHIFT_BITS : DATA_W;
   localparam int unsigned SHORT_SHIFT = SHIFT_W - SHORT_BITS;

   logic [SHIFT_W-1:0] tdi_sr_ff, tdi_sr_in;
   logic [SHIFT_W-1:0] tdo_sr_ff, tdo_sr_in;
   logic [DATA_W-1:0]  cap_ff, cap_in;
   logic [DATA_W-1:0]  din_short, tdo_short;

   // 8-bit words are left-aligned so the MSB always leaves first
   assign din_short = (data_in  & DATA_W'(8'hFF)) << SHORT_SHIFT;
   assign tdo_short = (tdo_bits & DATA_W'(8'hFF)) << SHORT_SHIFT;

   always_comb begin
      tdi_sr_in = tdi_sr_ff;
      tdo_sr_in = tdo_sr_ff;
      cap_in    = cap_ff;
      if (ctrl.load) begin
         tdi_sr_in = ctrl.short_len ? din_short[SHIFT_W-1:0] : data_in[SHIFT_W-1:0];
         tdo_sr_in = ctrl.short_len ? tdo_short[SHIFT_W-1:0] : tdo_bits[SHIFT_W-1:0];
         cap_in    = '0;
      end else if (ctrl.step) begin
         tdi_sr_in = tdi_sr_ff << 1;
         tdo_sr_in = tdo_sr_ff << 1;
         cap_in    = {cap_ff[DATA_W-2:0], tdo_sr_ff[SHIFT_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      tdi_sr_ff <= tdi_sr_in;
      tdo_sr_ff <= tdo_sr_in;
      cap_ff    <= cap_in;
   end

   assign tdi_bit  = tdi_sr_ff[SHIFT_W-1];
   assign captured = cap_ff;

endmodule

// ----- rtl/core/sbw_seq.sv -----
// Cycle sequencer: TAP walk, data, update and return cycles, TCLK latch, output register.
`timescale 1ns / 1ps
module sbw_seq import sbw_pkg::*; #(
   parameter int unsigned MAX_SHIFT_BITS = MAX_SHIFT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [OP_W-1:0]    req_opcode,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sbw_beat_type       beat,
   output sbw_shift_ctrl_type shift_ctrl,
   input  logic               tdi_bit,
   input  logic [DATA_W-1:0]  captured
);

   localparam int unsigned SHIFT_W = (MAX_SHIFT_BITS < DATA_W) ? MAX_SHIFT_BITS : DATA_W;
   localparam int unsigned CNT_W   = $clog2(SHIFT_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DATA,
      ST_UPDATE,
      ST_RETURN
   } state_type;

   state_type          state_ff, state_in;
   logic               valid_ff, valid_in;
   logic               tclk_ff, tclk_in;
   sbw_beat_type       beat_ff, beat_in;
   logic [3:0]         walk_ff, walk_in;
   logic [1:0]         walk_cnt_ff, walk_cnt_in;
   logic [CNT_W-1:0]   bits_ff, bits_in;
   logic               emit;

   assign emit      = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && emit;

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff && !rsp_ready;
      tclk_in     = tclk_ff;
      beat_in     = beat_ff;
      walk_in     = walk_ff;
      walk_cnt_in = walk_cnt_ff;
      bits_in     = bits_ff;
      shift_ctrl  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_opcode)
                  OP_IR_SHIFT8, OP_DR_SHIFT8, OP_DR_SHIFT16: begin
                     shift_ctrl.load      = 1'b1;
                     shift_ctrl.short_len = (req_opcode != OP_DR_SHIFT16);
                     bits_in     = (req_opcode == OP_DR_SHIFT16) ? CNT_W'(SHIFT_W)
                                                                  : CNT_W'(SHORT_BITS);
                     walk_in     = (req_opcode == OP_IR_SHIFT8) ? 4'b1100 : 4'b1000;
                     walk_cnt_in = (req_opcode == OP_IR_SHIFT8) ? 2'd3 : 2'd2;
                     state_in    = ST_WALK;
                  end
                  OP_TCLK_CLR, OP_TCLK_SET: begin
                     beat_in               = '0;
                     beat_in.restore_level = tclk_ff;
                     beat_in.tdi_level     = (req_opcode == OP_TCLK_SET);
                     beat_in.last          = 1'b1;
                     valid_in              = 1'b1;
                     tclk_in               = (req_opcode == OP_TCLK_SET);
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (emit) begin
               beat_in               = '0;
               beat_in.tms_level     = walk_ff[3];
               beat_in.restore_level = walk_ff[3];
               valid_in              = 1'b1;
               walk_in               = walk_ff << 1;
               walk_cnt_in           = walk_cnt_ff - 2'd1;
               if (walk_cnt_ff == 2'd0) state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (emit) begin
               beat_in             = '0;
               beat_in.tms_level   = (bits_ff == CNT_W'(1));
               beat_in.tdi_level   = tdi_bit;
               beat_in.tdo_sampled = 1'b1;
               valid_in            = 1'b1;
               shift_ctrl.step     = 1'b1;
               bits_in             = bits_ff - CNT_W'(1);
               if (bits_ff == CNT_W'(1)) state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (emit) begin
               beat_in               = '0;
               beat_in.tms_level     = 1'b1;
               beat_in.restore_level = 1'b1;
               valid_in              = 1'b1;
               state_in              = ST_RETURN;
            end
         end
         ST_RETURN: begin
            if (emit) begin
               beat_in               = '0;
               beat_in.restore_level = tclk_ff;
               beat_in.tdi_level     = tclk_ff;
               beat_in.data_out      = captured;
               beat_in.last          = 1'b1;
               valid_in              = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      beat_ff     <= beat_in;
      walk_ff     <= walk_in;
      walk_cnt_ff <= walk_cnt_in;
      bits_ff     <= bits_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         tclk_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         tclk_ff  <= tclk_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign beat      = beat_ff;

endmodule

// ----- rtl/core/spy_bi_wire_jtag_master.sv -----
// Top level: Spy-Bi-Wire JTAG master, one command in, one beat per SBW cycle out.
//
// Usage:
//   req_ch takes one command beat: opcode (IR shift 8, DR shift 8, DR shift 16,
//   TCLK clear, TCLK set), data_in shifted MSB first and tdo_bits, the TDO levels
//   the target returns in the data cycles. Unused opcodes are taken and dropped.
//   rsp_ch gives one beat per SBW cycle: TMS, TCLK restore level, TDI, a TDO
//   sample flag, the captured word (on the final beat of a shift) and last.
//   A shift command is taken in idle and its first beat is registered in the
//   walk state; TCLK commands register their single beat as they are taken.
//   Throughput: one beat per cycle while rsp_ch is ready, so a shift of n bits
//   gives n+5 (DR) or n+6 (IR) beats: 14, 13 and 21 beats for IR 8, DR 8
//   and DR 16. The data cycles run through the TDI/TDO shift registers one
//   bit per cycle while rsp_ch is ready, counted by the sequencer.
//   A new command is taken only when the sequencer is idle and the output
//   register is free or being emptied.
//   Reset clears the sequencer, drops any pending beat and latches TCLK low.
//   When rsp_ch stalls, the held beat stays and the sequence waits.
`timescale 1ns / 1ps
module spy_bi_wire_jtag_master import sbw_pkg::*; #(
   parameter int unsigned MAX_SHIFT_BITS = MAX_SHIFT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sbw_req_if.sink    req_ch,
   sbw_rsp_if.source  rsp_ch
);

   sbw_shift_ctrl_type shift_ctrl;
   sbw_beat_type       beat;
   logic               tdi_bit;
   logic [DATA_W-1:0]  captured;

   sbw_seq #(.MAX_SHIFT_BITS(MAX_SHIFT_BITS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .beat       (beat),
      .shift_ctrl (shift_ctrl),
      .tdi_bit    (tdi_bit),
      .captured   (captured)
   );

   sbw_shifter #(.MAX_SHIFT_BITS(MAX_SHIFT_BITS)) u_shifter (
      .clock    (clock),
      .data_in  (req_ch.data_in),
      .tdo_bits (req_ch.tdo_bits),
      .ctrl     (shift_ctrl),
      .tdi_bit  (tdi_bit),
      .captured (captured)
   );

   assign rsp_ch.tms_level     = beat.tms_level;
   assign rsp_ch.restore_level = beat.restore_level;
   assign rsp_ch.tdi_level     = beat.tdi_level;
   assign rsp_ch.tdo_sampled   = beat.tdo_sampled;
   assign rsp_ch.data_out      = beat.data_out;
   assign rsp_ch.last          = beat.last;

endmodule

// ----- rtl/core/sbw_checker.sv -----
// Checker: port-level properties of the SBW master, bound to the top level.
`timescale 1ns / 1ps
module sbw_checker import sbw_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              tms_level,
   input logic              restore_level,
   input logic              tdi_level,
   input logic              tdo_sampled,
   input logic [DATA_W-1:0] data_out,
   input logic              last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_out) && $stable(last)
         && $stable(tms_level) && $stable(tdi_level))
      else $error("stalled beat changed");

   a_sample_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tdo_sampled |-> !restore_level && !last)
      else $error("sampled beat with restore or last");

   a_word_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last |-> data_out == '0)
      else $error("captured word outside final beat");

   a_walk_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !tdo_sampled && !last |-> restore_level == tms_level && !tdi_level)
      else $error("walk or update beat malformed");

endmodule

bind spy_bi_wire_jtag_master sbw_checker u_sbw_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .tms_level     (rsp_ch.tms_level),
   .restore_level (rsp_ch.restore_level),
   .tdi_level     (rsp_ch.tdi_level),
   .tdo_sampled   (rsp_ch.tdo_sampled),
   .data_out      (rsp_ch.data_out),
   .last          (rsp_ch.last)
);
